/* rtl/sgc_pkg.sv */
// Package: types and constants for the shifter gear classifier.
package sgc_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int POS_BITS       = 2 * SAMPLE_BITS;
    localparam int NUM_POS        = 8;
    localparam int POS_IDX_BITS   = 3;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CODE_BITS      = 3;
    localparam int BUTTON_BITS    = 8;
    localparam int SUM_BITS       = SAMPLE_BITS + 2;

    localparam logic [POS_IDX_BITS-1:0] REV_IDX = 3'd6;
    localparam logic [POS_IDX_BITS-1:0] NEU_IDX = 3'd7;

    localparam logic [CODE_BITS-1:0] CODE_NEUTRAL = 3'd0;
    localparam logic [CODE_BITS-1:0] CODE_REVERSE = 3'd7;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [POS_BITS-1:0]    pos_t;

    typedef struct packed {
        sample_t sample_x;
        sample_t sample_y;
        logic    host_ready;
    } in_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]   gear_code;
        logic                   report_valid;
        logic [BUTTON_BITS-1:0] button_bits;
    } out_item_t;

    function automatic sample_t pos_x(input pos_t p);
        return p[SAMPLE_BITS-1:0];
    endfunction

    function automatic sample_t pos_y(input pos_t p);
        return p[POS_BITS-1:SAMPLE_BITS];
    endfunction

endpackage

/* rtl/shifter_gear_classifier_top.sv */
// Top level: gear classifier with shared add and compare unit and stability tracker.
//
// Usage
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write one of
//   eight calibrated positions (gears 1 to 6, reverse, neutral). cfg_ready is
//   always high; indexes above seven are dropped. Write only while idle.
//   Input: in_valid/in_ready carry one lever sample and the host ready flag.
//   in_ready is high only while the sequencer is idle.
//   Output: out_valid/out_ready carry gear code, report flag and button map.
//   Timing: one sample occupies the sequencer from the transaction to the
//   result register: one to three boundary steps and one or two midpoint
//   steps on the shared four-operand adder and comparator, then one delivery
//   step. The next sample is accepted the cycle after that delivery step.
//   Stall: a finished result waits in the delivery step while the output
//   register is still full, so nothing is lost or overwritten.
//   Reset: calibration clears to zero, the history reads as all neutral and
//   both channels are empty.
module shifter_gear_classifier_top #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sgc_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sgc_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sgc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  sgc_pkg::pos_t                        cfg_data
);
    import sgc_pkg::*;

    localparam int RUN_BITS = $clog2(HISTORY_DEPTH + 1);
    localparam logic [RUN_BITS-1:0] RUN_FULL = RUN_BITS'(HISTORY_DEPTH);
    localparam logic [RUN_BITS-1:0] RUN_ONE  = RUN_BITS'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BND  = 3'd1;
    localparam logic [2:0] ST_UP   = 3'd2;
    localparam logic [2:0] ST_DN   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [1:0] LANE_REV  = 2'd0;
    localparam logic [1:0] LANE_LAST = 2'd2;

    pos_t                 pos_reg [NUM_POS];
    logic [2:0]           state_reg, state_next;
    logic [1:0]           lane_reg, lane_next;
    sample_t              x_reg, y_reg;
    logic                 hr_reg;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [CODE_BITS-1:0] last_reg, last_next;
    logic [RUN_BITS-1:0]  run_reg, run_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    sample_t               op_a, op_b, op_c, op_d;
    logic [SUM_BITS-1:0]   sum;
    sample_t               bound, mid;
    logic                  x_lt, y_gt, y_lt;
    logic [POS_IDX_BITS-1:0] up_idx, dn_idx;
    logic                  slot_free, stable;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign up_idx = (lane_reg == LANE_REV) ? REV_IDX : {lane_reg - 2'd1, 1'b0};
    assign dn_idx = up_idx + POS_IDX_BITS'(1);

    always_comb
    begin
        op_a = pos_y(pos_reg[up_idx]);
        op_b = pos_y(pos_reg[NEU_IDX]);
        op_c = '0;
        op_d = '0;
        if (state_reg == ST_BND)
        begin
            unique case (lane_reg)
                2'd0:
                begin
                    op_a = pos_x(pos_reg[REV_IDX]);
                    op_b = pos_x(pos_reg[REV_IDX]);
                    op_c = pos_x(pos_reg[0]);
                    op_d = pos_x(pos_reg[1]);
                end
                2'd1:
                begin
                    op_a = pos_x(pos_reg[0]);
                    op_b = pos_x(pos_reg[1]);
                    op_c = pos_x(pos_reg[2]);
                    op_d = pos_x(pos_reg[3]);
                end
                default:
                begin
                    op_a = pos_x(pos_reg[2]);
                    op_b = pos_x(pos_reg[3]);
                    op_c = pos_x(pos_reg[4]);
                    op_d = pos_x(pos_reg[5]);
                end
            endcase
        end
        else if (state_reg == ST_DN)
        begin
            op_a = pos_y(pos_reg[dn_idx]);
        end
    end

    assign sum   = SUM_BITS'(op_a) + SUM_BITS'(op_b) + SUM_BITS'(op_c) + SUM_BITS'(op_d);
    assign bound = sum[SUM_BITS-1:2];
    assign mid   = sum[SAMPLE_BITS:1];
    assign x_lt  = x_reg < bound;
    assign y_gt  = y_reg > mid;
    assign y_lt  = y_reg < mid;

    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        stable         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lane_next  = LANE_REV;
                    state_next = ST_BND;
                end
            end
            ST_BND:
            begin
                if (x_lt)
                begin
                    state_next = ST_UP;
                end
                else if (lane_reg == LANE_LAST)
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = ST_UP;
                end
                else
                begin
                    lane_next = lane_reg + 2'd1;
                end
            end
            ST_UP:
            begin
                if (y_gt)
                begin
                    code_next  = (lane_reg == LANE_REV) ? CODE_REVERSE
                                                        : CODE_BITS'(up_idx) + CODE_BITS'(1);
                    state_next = ST_DONE;
                end
                else if (lane_reg == LANE_REV)
                begin
                    code_next  = CODE_NEUTRAL;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DN;
                end
            end
            ST_DN:
            begin
                code_next  = y_lt ? CODE_BITS'(dn_idx) + CODE_BITS'(1) : CODE_NEUTRAL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    if (code_reg == last_reg)
                    begin
                        run_next = (run_reg == RUN_FULL) ? RUN_FULL : run_reg + RUN_ONE;
                    end
                    else
                    begin
                        run_next = RUN_ONE;
                    end
                    last_next = code_reg;
                    stable    = (run_next == RUN_FULL);
                    out_next.gear_code    = code_reg;
                    out_next.report_valid = stable && hr_reg;
                    out_next.button_bits  = (stable && hr_reg)
                                            ? BUTTON_BITS'(1) << code_reg
                                            : '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lane_reg      <= LANE_REV;
            last_reg      <= CODE_NEUTRAL;
            run_reg       <= RUN_FULL;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_POS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            last_reg      <= last_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && (cfg_index < CFG_INDEX_BITS'(NUM_POS)))
            begin
                pos_reg[cfg_index[POS_IDX_BITS-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        out_reg  <= out_next;
        if (in_valid && in_ready)
        begin
            x_reg  <= in_data.sample_x;
            y_reg  <= in_data.sample_y;
            hr_reg <= in_data.host_ready;
        end
    end

endmodule
